[hw/rtl/rfc_pkg.sv]
package rfc_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 6;
    localparam int DIM_W     = 7;
    localparam int RAND_W    = 31;
    localparam int CNT_W     = 13;
    localparam int IDX_W     = 12;
    localparam int STEP_W    = 5;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } mod_res_t;

    // lowest set bit of a row word
    function automatic logic [COL_W-1:0] first_set(input logic [MAX_COLS-1:0] w);
        logic [COL_W-1:0] pos;
        pos = '0;
        for (int i = MAX_COLS - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = COL_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

[hw/rtl/rfc_ram.sv]
module rfc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/rfc_mod.sv]
module rfc_mod
    import rfc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAND_W-1:0] rand_col,
    input  logic [RAND_W-1:0] rand_row,
    input  logic [DIM_W-1:0]  cols,
    input  logic [DIM_W-1:0]  rows,
    output mod_res_t          res
);

    // restoring remainder, one dividend bit per cycle on both lanes
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RAND_W-1:0] a_reg, a_next;
    logic [RAND_W-1:0] b_reg, b_next;
    logic [DIM_W-1:0]  da_reg, da_next;
    logic [DIM_W-1:0]  db_reg, db_next;
    logic [COL_W-1:0]  ra_reg, ra_next;
    logic [ROW_W-1:0]  rb_reg, rb_next;
    logic [DIM_W-1:0]  ta, tb;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        da_next   = da_reg;
        db_next   = db_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        ta        = {ra_reg, a_reg[RAND_W-1]};
        tb        = {rb_reg, b_reg[RAND_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            a_next    = rand_col;
            b_next    = rand_row;
            da_next   = cols;
            db_next   = rows;
            ra_next   = '0;
            rb_next   = '0;
        end else if (busy_reg) begin
            a_next  = {a_reg[RAND_W-2:0], 1'b0};
            b_next  = {b_reg[RAND_W-2:0], 1'b0};
            ra_next = (ta >= da_reg) ? COL_W'(ta - da_reg) : COL_W'(ta);
            rb_next = (tb >= db_reg) ? ROW_W'(tb - db_reg) : ROW_W'(tb);
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(RAND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        a_reg  <= a_next;
        b_reg  <= b_next;
        da_reg <= da_next;
        db_reg <= db_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
    end

    assign res.done = done_reg;
    assign res.col  = ra_reg;
    assign res.row  = rb_reg;

endmodule

[hw/rtl/random_start_free_cell_allocator_top.sv]
// channel | ports                        | contents (low bit up)
// input   | s_tvalid s_tready s_tdata    | tdata: rand_col[30:0], rand_row[61:31]
//         | s_tuser                      | tuser: clear_first
// result  | m_tvalid m_tready m_tdata    | tdata: cell_col[5:0], cell_row[11:6],
//         | m_tuser                      |        order_index[23:12]; tuser: status
// config  | cfg_wr_en cfg_index cfg_wdata| index 0 cols_in_use, 1 rows_in_use
//
// one item at a time: the accept, the start cell remainders (one bit per
// cycle), then a read and a check state per occupancy row of the map ram,
// up to rows+1 rows, then the result goes to the output register.
// reset clears the per-row valid bits at once, so the map reads as empty with
// no clearing pass; clear_first does the same on accept.
// a waiting result holds in the output register while the next item is taken.
module random_start_free_cell_allocator_top
    import rfc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // rand_col, rand_row, zero pad
    input  logic             s_tuser,   // clear_first
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // cell_col, cell_row, order_index
    output logic             m_tuser,   // status
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_RD   = 5'b00100,
        ST_CHK  = 5'b01000,
        ST_PUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]    cols_reg, cols_next;
    logic [DIM_W-1:0]    rows_reg, rows_next;
    logic [DIM_W-1:0]    cols, rows;
    logic [MAX_ROWS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic [COL_W-1:0]    lo_reg, lo_next;
    logic [COL_W-1:0]    start_x_reg, start_x_next;
    logic [ROW_W-1:0]    y_reg, y_next;
    logic [DIM_W-1:0]    pass_reg, pass_next;

    logic [COL_W-1:0]    res_col_reg, res_col_next;
    logic [ROW_W-1:0]    res_row_reg, res_row_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic                res_full_reg, res_full_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [23:0]         m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic                in_acc;
    mod_res_t            mres;

    logic                ram_we;
    logic [MAX_COLS-1:0] ram_wdata, ram_rdata;
    logic [MAX_COLS-1:0] word, col_mask, lo_mask, tail_mask, free_mask;
    logic [COL_W-1:0]    pos;
    logic [DIM_W-1:0]    y_inc;

    // zero reads as one, above the limit as the limit
    assign cols = (cols_reg == '0) ? DIM_W'(1) :
                  (cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_reg;
    assign rows = (rows_reg == '0) ? DIM_W'(1) :
                  (rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    rfc_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_acc),
        .rand_col (s_tdata[RAND_W-1:0]),
        .rand_row (s_tdata[2*RAND_W-1:RAND_W]),
        .cols     (cols),
        .rows     (rows),
        .res      (mres)
    );

    rfc_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (y_reg),
        .wr_data (ram_wdata),
        .rd_addr (y_reg),
        .rd_data (ram_rdata)
    );

    // free cells of the current row that this pass may take
    always_comb begin
        word      = valid_reg[y_reg] ? ram_rdata : '0;
        col_mask  = (cols == DIM_W'(MAX_COLS)) ? '1 :
                    ((MAX_COLS'(1) << cols[COL_W-1:0]) - MAX_COLS'(1));
        lo_mask   = {MAX_COLS{1'b1}} << lo_reg;
        tail_mask = (pass_reg == rows) ?
                    ((MAX_COLS'(1) << start_x_reg) - MAX_COLS'(1)) : '1;
        free_mask = ~word & col_mask & lo_mask & tail_mask;
        pos       = first_set(free_mask);
        ram_wdata = word | (MAX_COLS'(1) << pos);
        y_inc     = DIM_W'(y_reg) + DIM_W'(1);
    end

    always_comb begin
        state_next    = state_reg;
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        start_x_next  = start_x_reg;
        y_next        = y_reg;
        pass_next     = pass_reg;
        res_col_next  = res_col_reg;
        res_row_next  = res_row_reg;
        res_idx_next  = res_idx_reg;
        res_full_next = res_full_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_COLS: cols_next = cfg_wdata;
                REG_ROWS: rows_next = cfg_wdata;
                default:  ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        valid_next = '0;
                        count_next = '0;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (mres.done) begin
                    start_x_next = mres.col;
                    lo_next      = mres.col;
                    y_next       = mres.row;
                    pass_next    = '0;
                    state_next   = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (free_mask != '0) begin
                    ram_we              = 1'b1;
                    valid_next[y_reg]   = 1'b1;
                    res_col_next        = pos;
                    res_row_next        = y_reg;
                    res_idx_next        = count_reg[IDX_W-1:0];
                    res_full_next       = 1'b0;
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_PUSH;
                end else if (pass_reg == rows) begin
                    res_col_next  = '0;
                    res_row_next  = '0;
                    res_idx_next  = '0;
                    res_full_next = 1'b1;
                    state_next    = ST_PUSH;
                end else begin
                    // on to the next row, wrapping to row 0
                    pass_next  = pass_reg + DIM_W'(1);
                    lo_next    = '0;
                    y_next     = (y_inc == rows) ? '0 : y_inc[ROW_W-1:0];
                    state_next = ST_RD;
                end
            end
            ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_idx_reg, res_row_reg, res_col_reg};
                    m_tuser_next  = res_full_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cols_reg     <= DIM_W'(64);
            rows_reg     <= DIM_W'(36);
            valid_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        lo_reg       <= lo_next;
        start_x_reg  <= start_x_next;
        y_reg        <= y_next;
        pass_reg     <= pass_next;
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
        res_idx_reg  <= res_idx_next;
        res_full_reg <= res_full_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
